// ===== rtl/core/irbd_pkg.sv =====
// Shared constants, types and codes for the infrared beam calibrated detector.
package irbd_pkg;

	localparam int NUM_SENSORS = 6;
	localparam int ADC_BITS    = 10;
	localparam int SENSOR_W    = 3;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int SENS_FRAC   = 16;

	localparam int ADDR_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int CNT_W   = CFG_W + ((NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 0);
	localparam int DIFF_W  = ADC_BITS + 1;
	localparam int PROD_W  = ADC_BITS + CFG_W;

	localparam logic [CFG_IDX_W-1:0] REG_SKIP_ROUNDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_ROUNDS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd2;

	localparam int SKIP_ROUNDS_RST = 256;
	localparam int CAL_ROUNDS_RST  = 256;
	localparam logic [CFG_W-1:0] SENSITIVITY_RST = 16'd19661;

	typedef enum logic [2:0] {
		OP_SKIP,
		OP_CAL,
		OP_FINISH,
		OP_READY,
		OP_OOR,
		OP_RECAL
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic                      oor_ready;
		logic [SENSOR_W-1:0]       sensor;
		logic [ADDR_W-1:0]         addr;
		logic signed [DIFF_W-1:0]  diff;
	} item_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_W-1:0]    addr;
		logic [ADC_BITS-1:0]  data;
	} ram_wr_t;

endpackage

// ===== rtl/core/irbd_peak_ram.sv =====
// Per-sensor peak difference memory with registered read and valid bits.
module irbd_peak_ram (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [irbd_pkg::ADDR_W-1:0]       rd_addr,
	output logic [irbd_pkg::ADC_BITS-1:0]     rd_data,
	input  irbd_pkg::ram_wr_t                 wr,
	input  logic                              clear
);
	import irbd_pkg::*;

	logic [ADC_BITS-1:0]    mem [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] valid_q;
	logic [ADC_BITS-1:0]    rd_data_q;

	// Entry storage and read port; an entry never written since clear reads as zero.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	// Clear wins over a write landing on the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/irbd_seq.sv =====
// Configuration registers, calibration phase sequencer and per-item decode.
module irbd_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [irbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irbd_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                issue,
	input  logic                                action,
	input  logic [irbd_pkg::SENSOR_W-1:0]       sensor,
	input  logic [irbd_pkg::ADC_BITS-1:0]       ambient,
	input  logic [irbd_pkg::ADC_BITS-1:0]       lit,
	output irbd_pkg::item_t                     item,
	output logic [irbd_pkg::CFG_W-1:0]          sens_cal
);
	import irbd_pkg::*;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_CAL,
		PH_READY
	} phase_t;

	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   skip_items_q;
	logic [CNT_W-1:0]   cal_items_q;
	logic [CFG_W-1:0]   sens_cfg_q;
	logic [CFG_W-1:0]   sens_cal_q;

	logic               in_range;
	logic               to_cal;
	logic [CNT_W-1:0]   cnt_base;
	logic [CNT_W-1:0]   cnt_inc;
	logic               cal_done;
	op_t                op;

	// Registers hold item counts, rounds times the number of sensors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_items_q <= CNT_W'(SKIP_ROUNDS_RST * NUM_SENSORS);
			cal_items_q  <= CNT_W'(CAL_ROUNDS_RST * NUM_SENSORS);
			sens_cfg_q   <= SENSITIVITY_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SKIP_ROUNDS: skip_items_q <= CNT_W'(cfg_data * NUM_SENSORS);
				REG_CAL_ROUNDS:  cal_items_q  <= CNT_W'(cfg_data * NUM_SENSORS);
				REG_SENSITIVITY: sens_cfg_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		in_range = int'(sensor) < NUM_SENSORS;
		to_cal   = (phase_q == PH_SKIP) && (cnt_q >= skip_items_q);
		cnt_base = to_cal ? '0 : cnt_q;
		cnt_inc  = cnt_base + CNT_W'(1);
		cal_done = cnt_inc >= cal_items_q;

		if (action) begin
			op = OP_RECAL;
		end else if (!in_range) begin
			op = OP_OOR;
		end else begin
			case (phase_q)
				PH_SKIP:  op = to_cal ? (cal_done ? OP_FINISH : OP_CAL) : OP_SKIP;
				PH_CAL:   op = cal_done ? OP_FINISH : OP_CAL;
				PH_READY: op = OP_READY;
				default:  op = OP_SKIP;
			endcase
		end

		item.op        = op;
		item.oor_ready = (phase_q == PH_READY);
		item.sensor    = sensor;
		item.addr      = sensor[ADDR_W-1:0];
		item.diff      = $signed({1'b0, lit}) - $signed({1'b0, ambient});
	end

	// Phase and count advance only at the transfer of an item; out-of-range and ready items leave them as they are.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			cnt_q      <= '0;
			sens_cal_q <= SENSITIVITY_RST;
		end else if (issue) begin
			case (op)
				OP_RECAL: begin
					phase_q <= PH_SKIP;
					cnt_q   <= '0;
				end
				OP_SKIP: begin
					cnt_q <= cnt_inc;
				end
				OP_CAL: begin
					phase_q <= PH_CAL;
					cnt_q   <= cnt_inc;
				end
				OP_FINISH: begin
					phase_q    <= PH_READY;
					cnt_q      <= cnt_inc;
					sens_cal_q <= sens_cfg_q;
				end
				default: ;
			endcase
		end
	end

	assign sens_cal = sens_cal_q;

endmodule

// ===== rtl/core/irbd_eval.sv =====
// Read-modify-write pipeline: peak update, threshold multiply, beam compare, output register.
module irbd_eval (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  irbd_pkg::item_t                   item,
	input  logic [irbd_pkg::CFG_W-1:0]        sens_cal,
	input  logic [irbd_pkg::ADC_BITS-1:0]     rd_data,
	output logic                              advance,
	output irbd_pkg::ram_wr_t                 wr,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [irbd_pkg::SENSOR_W-1:0]     which_sensor,
	output logic                              blocked,
	output logic                              ready_res,
	output logic [irbd_pkg::ADC_BITS-1:0]     level
);
	import irbd_pkg::*;

	logic                     valid_s1;
	item_t                    item_s1;
	ram_wr_t                  fwd_q;

	logic                     valid_s2;
	op_t                      op_s2;
	logic                     oor_ready_s2;
	logic [SENSOR_W-1:0]      sensor_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [PROD_W-1:0]        prod_s2;

	logic                     out_valid_q;
	logic [SENSOR_W-1:0]      which_sensor_q;
	logic                     blocked_q;
	logic                     ready_res_q;
	logic [ADC_BITS-1:0]      level_q;

	logic [ADC_BITS-1:0]      peak_cur;
	logic [ADC_BITS-1:0]      peak_new;
	logic [ADC_BITS-1:0]      peak_mul;
	logic [PROD_W-1:0]        prod;
	logic                     is_cal;
	logic [ADC_BITS-1:0]      limit;
	logic                     blk;
	logic                     rdy;
	logic [ADC_BITS-1:0]      lvl;

	assign advance = !out_valid_q || !out_stall;

	// Stage 1: memory data arrives; forward the write from the previous advance.
	always_comb begin
		peak_cur = (fwd_q.en && (fwd_q.addr == item_s1.addr)) ? fwd_q.data : rd_data;
		peak_new = (item_s1.diff > $signed({1'b0, peak_cur}))
			? item_s1.diff[ADC_BITS-1:0] : peak_cur;
		is_cal   = (item_s1.op == OP_CAL) || (item_s1.op == OP_FINISH);
		peak_mul = (item_s1.op == OP_FINISH) ? peak_new : peak_cur;
		prod     = PROD_W'(peak_mul) * PROD_W'(sens_cal);
		wr.en    = advance && valid_s1 && is_cal;
		wr.addr  = item_s1.addr;
		wr.data  = peak_new;
	end

	// Stage 2: threshold from the registered product, then compare.
	always_comb begin
		limit = prod_s2[PROD_W-1:SENS_FRAC];
		blk   = (op_s2 == OP_READY) && (diff_s2 < $signed({1'b0, limit}));
		rdy   = (op_s2 == OP_FINISH) || (op_s2 == OP_READY)
			|| ((op_s2 == OP_OOR) && oor_ready_s2);
		lvl   = ((op_s2 == OP_FINISH) || (op_s2 == OP_READY)) ? limit : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_q       <= '0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			fwd_q       <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1        <= item;
			op_s2          <= item_s1.op;
			oor_ready_s2   <= item_s1.oor_ready;
			sensor_s2      <= item_s1.sensor;
			diff_s2        <= item_s1.diff;
			prod_s2        <= prod;
			which_sensor_q <= sensor_s2;
			blocked_q      <= blk;
			ready_res_q    <= rdy;
			level_q        <= lvl;
		end
	end

	assign out_valid    = out_valid_q;
	assign which_sensor = which_sensor_q;
	assign blocked      = blocked_q;
	assign ready_res    = ready_res_q;
	assign level        = level_q;

endmodule

// ===== rtl/core/ir_beam_calibrated_detector.sv =====
// Top level of the infrared beam calibrated detector.
// The block takes one item per clock cycle when the output side keeps up, and each result
// passes in order through the registered read of the per-sensor peak memory, the
// threshold multiply and the compare into the output register. A stall on the output
// while a result waits there freezes the whole pipeline and is passed straight
// back as in_stall. After a restart (reset or a recalibrate item) the block drops
// skip_rounds rounds of samples, then tracks each sensor's largest lit minus ambient for
// cal_rounds rounds, and on the last calibration item fixes every threshold at
// peak * sensitivity / 65536 using the sensitivity in force at that moment. From then on a
// sensor reads blocked when its difference falls below its threshold. Sensors are expected
// round-robin. Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no item is in flight.
module ir_beam_calibrated_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irbd_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [irbd_pkg::SENSOR_W-1:0]     sensor,
	input  logic [irbd_pkg::ADC_BITS-1:0]     ambient,
	input  logic [irbd_pkg::ADC_BITS-1:0]     lit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [irbd_pkg::SENSOR_W-1:0]     which_sensor,
	output logic                              blocked,
	output logic                              ready_res,
	output logic [irbd_pkg::ADC_BITS-1:0]     level
);
	import irbd_pkg::*;

	item_t                 item;
	logic [CFG_W-1:0]      sens_cal;
	logic [ADC_BITS-1:0]   rd_data;
	ram_wr_t               wr;
	logic                  advance;
	logic                  issue;
	logic                  rd_en;
	logic                  clear;

	assign cfg_ready = 1'b1;
	assign in_stall  = !advance;

	// An input transfer happens whenever the pipeline moves and an item is offered.
	assign issue = in_valid && advance;

	// Read the peak only for items that use it; out-of-range sensors never touch memory.
	assign rd_en = issue
		&& ((item.op == OP_CAL) || (item.op == OP_FINISH) || (item.op == OP_READY));

	// Recalibrate drops all peaks at once through the valid bits.
	assign clear = issue && (item.op == OP_RECAL);

	irbd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.issue     (issue),
		.action    (action),
		.sensor    (sensor),
		.ambient   (ambient),
		.lit       (lit),
		.item      (item),
		.sens_cal  (sens_cal)
	);

	irbd_peak_ram u_peak_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (item.addr),
		.rd_data (rd_data),
		.wr      (wr),
		.clear   (clear)
	);

	irbd_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.item         (item),
		.sens_cal     (sens_cal),
		.rd_data      (rd_data),
		.advance      (advance),
		.wr           (wr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.which_sensor (which_sensor),
		.blocked      (blocked),
		.ready_res    (ready_res),
		.level        (level)
	);

endmodule
